// File: design/hcpm_pkg.sv
// Shared types, constants and register codes for the height-to-color pixel mapper.
package hcpm_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_PEAK = 2'd3;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int NUM_CHAN = 3;
    localparam int HEIGHT_W = 16;
    localparam int IDX_W   = 18;
    localparam int PIXEL_W = 32;

    localparam logic [COLOR_W-1:0] COLOR_LOW_RST  = 24'd496916;
    localparam logic [COLOR_W-1:0] COLOR_MID_RST  = 24'd1397897;
    localparam logic [COLOR_W-1:0] COLOR_HIGH_RST = 24'd6316128;
    localparam logic [COLOR_W-1:0] COLOR_PEAK_RST = 24'd16777215;

    // Segment geometry
    localparam int D_W = 10;
    localparam logic [D_W-1:0] SEG_SPAN = 10'd600;
    localparam logic signed [HEIGHT_W-1:0] SEG1_BASE   = 16'sd600;
    localparam logic signed [HEIGHT_W-1:0] SEG2_BASE   = 16'sd1200;
    localparam logic signed [HEIGHT_W-1:0] TOP_CAP     = 16'sd1599;
    localparam logic signed [HEIGHT_W-1:0] WATER_FLOOR = -16'sd511;
    localparam int MAG_W = 9;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA    = 8'd255;

    // Exact floor(s/600) for s < 2^18: q = (s * RECIP) >> RECIP_SHIFT
    localparam int SUM_W       = 18;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP = 19'd447393;
    localparam int QPROD_W     = SUM_W + RECIP_W;

    // Default tiling
    localparam int GRID_TILES_DEF  = 64;
    localparam int TILE_PIXELS_DEF = 8;

    typedef logic [COLOR_W-1:0] color_t;

    // Decoded height: segment endpoints and offset, or the water shade
    typedef struct packed {
        logic              water;
        logic [CHAN_W-1:0] blue;
        logic [D_W-1:0]    d;
        color_t            c1;
        color_t            c2;
    } seg_t;

    // Per-stage load enables for the blend lanes
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } adv_t;

endpackage

// File: design/hcpm_seg_sel.sv
// Height decode: clamp, segment selection and water shade.
module hcpm_seg_sel (
    input  logic signed [hcpm_pkg::HEIGHT_W-1:0] height,
    input  hcpm_pkg::color_t                     color_low,
    input  hcpm_pkg::color_t                     color_mid,
    input  hcpm_pkg::color_t                     color_high,
    input  hcpm_pkg::color_t                     color_peak,
    output hcpm_pkg::seg_t                       seg
);

    logic [hcpm_pkg::MAG_W-1:0]             mag;
    logic signed [hcpm_pkg::HEIGHT_W-1:0]   hcap;
    logic signed [hcpm_pkg::HEIGHT_W-1:0]   hoff;

    // Clamp negative heights; the shade below halves the magnitude toward zero
    always_comb begin
        if (height < hcpm_pkg::WATER_FLOOR) begin
            mag = hcpm_pkg::MAG_W'(-hcpm_pkg::WATER_FLOOR);
        end else begin
            mag = hcpm_pkg::MAG_W'(-height);
        end
    end

    // Pick the segment and its offset
    always_comb begin
        hcap = (height > hcpm_pkg::TOP_CAP) ? hcpm_pkg::TOP_CAP : height;
        seg.water = height[hcpm_pkg::HEIGHT_W-1];
        seg.blue  = hcpm_pkg::CHAN_MAX - mag[hcpm_pkg::MAG_W-1:1];
        if (height < hcpm_pkg::SEG1_BASE) begin
            hoff   = height;
            seg.c1 = color_low;
            seg.c2 = color_mid;
        end else if (height < hcpm_pkg::SEG2_BASE) begin
            hoff   = height - hcpm_pkg::SEG1_BASE;
            seg.c1 = color_mid;
            seg.c2 = color_high;
        end else begin
            hoff   = hcap - hcpm_pkg::SEG2_BASE;
            seg.c1 = color_high;
            seg.c2 = color_peak;
        end
        seg.d = hoff[hcpm_pkg::D_W-1:0];
    end

endmodule

// File: design/hcpm_chan_lane.sv
// One color channel blend: weighted products, sum, exact divide by the span.
module hcpm_chan_lane (
    input  logic                          aclk,
    input  hcpm_pkg::adv_t                adv,
    input  logic [hcpm_pkg::CHAN_W-1:0]   c1,
    input  logic [hcpm_pkg::CHAN_W-1:0]   c2,
    input  logic [hcpm_pkg::D_W-1:0]      d,
    output logic [hcpm_pkg::CHAN_W-1:0]   q
);

    logic [hcpm_pkg::SUM_W-1:0]   p1_reg;
    logic [hcpm_pkg::SUM_W-1:0]   p2_reg;
    logic [hcpm_pkg::SUM_W-1:0]   sum_reg;
    logic [hcpm_pkg::CHAN_W-1:0]  q_reg;
    logic [hcpm_pkg::D_W-1:0]     dc;
    logic [hcpm_pkg::QPROD_W-1:0] qprod;

    assign dc    = hcpm_pkg::SEG_SPAN - d;
    assign qprod = hcpm_pkg::QPROD_W'(sum_reg) * hcpm_pkg::QPROD_W'(hcpm_pkg::RECIP);

    // Weight both endpoints
    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            p1_reg <= hcpm_pkg::SUM_W'(c1) * hcpm_pkg::SUM_W'(dc);
            p2_reg <= hcpm_pkg::SUM_W'(c2) * hcpm_pkg::SUM_W'(d);
        end
    end

    // Add the weighted terms
    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            sum_reg <= p1_reg + p2_reg;
        end
    end

    // Divide by the span through the reciprocal
    always_ff @(posedge aclk) begin
        if (adv.s4) begin
            q_reg <= qprod[hcpm_pkg::RECIP_SHIFT +: hcpm_pkg::CHAN_W];
        end
    end

    assign q = q_reg;

endmodule

// File: design/height_to_color_pixel_mapper_unit.sv
// Height-to-color pixel mapper top level: config registers, stage control, index path.
// Takes one pixel request per cycle while s_ready is high. Each request passes four
// register stages (height decode, channel products, product sum, reciprocal divide),
// and its texture index and RGBA color leave from the last stage. The sustained rate
// is one pixel per clock while m_ready stays high.
// Requests for absent tiles are dropped at the input and give no result. Each
// stage holds under backpressure; bubbles between requests are squeezed out.
// Palette registers take effect on requests accepted after the write.
module height_to_color_pixel_mapper_unit #(
    parameter int GRID_TILES  = hcpm_pkg::GRID_TILES_DEF,
    parameter int TILE_PIXELS = hcpm_pkg::TILE_PIXELS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [hcpm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hcpm_pkg::COLOR_W-1:0]          cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [5:0]                            s_tile_row,
    input  logic [5:0]                            s_tile_col,
    input  logic [2:0]                            s_sub_row,
    input  logic [2:0]                            s_sub_col,
    input  logic signed [hcpm_pkg::HEIGHT_W-1:0]  s_height,
    input  logic                                  s_tile_present,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [hcpm_pkg::IDX_W-1:0]            m_pixel_index,
    output logic [hcpm_pkg::PIXEL_W-1:0]          m_pixel_color
);

    localparam int IW = hcpm_pkg::IDX_W;
    localparam int CW = hcpm_pkg::CHAN_W;

    hcpm_pkg::color_t color_low_reg, color_mid_reg, color_high_reg, color_peak_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next;
    logic rdy1, rdy2, rdy3, rdy4;
    hcpm_pkg::adv_t adv;

    hcpm_pkg::seg_t seg_dec;
    hcpm_pkg::seg_t seg1_reg;
    logic [IW-1:0]  idx_next;
    logic [IW-1:0]  idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic           water2_reg, water3_reg, water4_reg;
    logic [CW-1:0]  blue2_reg, blue3_reg, blue4_reg;
    logic [CW-1:0]  q_chan [hcpm_pkg::NUM_CHAN];

    // Palette register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_low_reg  <= hcpm_pkg::COLOR_LOW_RST;
            color_mid_reg  <= hcpm_pkg::COLOR_MID_RST;
            color_high_reg <= hcpm_pkg::COLOR_HIGH_RST;
            color_peak_reg <= hcpm_pkg::COLOR_PEAK_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hcpm_pkg::REG_COLOR_LOW:  color_low_reg  <= cfg_wdata;
                hcpm_pkg::REG_COLOR_MID:  color_mid_reg  <= cfg_wdata;
                hcpm_pkg::REG_COLOR_HIGH: color_high_reg <= cfg_wdata;
                hcpm_pkg::REG_COLOR_PEAK: color_peak_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage ready chain: a stage advances when empty or when the next one moves
    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign adv     = '{s2: rdy2, s3: rdy3, s4: rdy4};

    // Drop absent tiles at the input
    assign v1_next = rdy1 ? (s_valid && s_tile_present) : v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Texture index, wrapped to its width
    assign idx_next = (IW'(s_tile_row) * IW'(TILE_PIXELS) + IW'(s_sub_row))
                      * IW'(GRID_TILES * TILE_PIXELS)
                      + IW'(s_tile_col) * IW'(TILE_PIXELS) + IW'(s_sub_col);

    hcpm_seg_sel u_seg_sel (
        .height     (s_height),
        .color_low  (color_low_reg),
        .color_mid  (color_mid_reg),
        .color_high (color_high_reg),
        .color_peak (color_peak_reg),
        .seg        (seg_dec)
    );

    // Stage 1: decoded height and index
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            seg1_reg <= seg_dec;
            idx1_reg <= idx_next;
        end
    end

    // Carry index and water shade alongside the blend lanes
    always_ff @(posedge aclk) begin
        if (rdy2) begin
            idx2_reg   <= idx1_reg;
            water2_reg <= seg1_reg.water;
            blue2_reg  <= seg1_reg.blue;
        end
        if (rdy3) begin
            idx3_reg   <= idx2_reg;
            water3_reg <= water2_reg;
            blue3_reg  <= blue2_reg;
        end
        if (rdy4) begin
            idx4_reg   <= idx3_reg;
            water4_reg <= water3_reg;
            blue4_reg  <= blue3_reg;
        end
    end

    // One blend lane per color channel
    for (genvar k = 0; k < hcpm_pkg::NUM_CHAN; k++) begin : g_lane
        hcpm_chan_lane u_lane (
            .aclk (aclk),
            .adv  (adv),
            .c1   (seg1_reg.c1[k*CW +: CW]),
            .c2   (seg1_reg.c2[k*CW +: CW]),
            .d    (seg1_reg.d),
            .q    (q_chan[k])
        );
    end

    // Result assembly
    assign m_valid       = v4_reg;
    assign m_pixel_index = idx4_reg;
    assign m_pixel_color = water4_reg
                         ? {hcpm_pkg::ALPHA, blue4_reg, {(2*CW){1'b0}}}
                         : {hcpm_pkg::ALPHA, q_chan[2], q_chan[1], q_chan[0]};

    // Present requests enter stage 1, absent ones never do
    a_present_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_tile_present) |=> v1_reg)
        else $error("present request did not enter the pipeline");

    a_absent_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_tile_present) |=> !v1_reg)
        else $error("absent request entered the pipeline");

    // A held stage keeps its request while the one after it is stalled
    a_stage3_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdy4) |=> (v3_reg && $stable(idx3_reg)))
        else $error("stage 3 request lost under backpressure");

    a_stage1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !rdy2) |=> (v1_reg && $stable(idx1_reg)))
        else $error("stage 1 request lost under backpressure");

endmodule
